// ----- rtl/tgq_pkg.sv -----
`default_nettype none
package tgq_pkg;

    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // CORDIC datapath width: angles on a 2^32-per-turn scale plus growth
    localparam int AW = 36;
    // serial multiplier operand width
    localparam int MW = 32;

    localparam logic signed [AW-1:0] HALF_TURN    = 36'sh0_8000_0000;
    localparam logic signed [AW-1:0] QUARTER_TURN = 36'sh0_4000_0000;
    localparam logic signed [AW-1:0] GAIN_Q30     = 36'sd652032875;
    localparam logic [65:0]          RANGE_SQ_MIN = 66'd429496;

    localparam logic [1:0] OP_TARGET = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_MS     = 2'd2;
    localparam logic [1:0] OP_SPARE  = 2'd3;

    localparam logic KIND_ACQ = 1'b0;
    localparam logic KIND_ATT = 1'b1;

    localparam logic [2:0] CFG_TIMEOUT  = 3'd0;
    localparam logic [2:0] CFG_PITCH    = 3'd1;
    localparam logic [2:0] CFG_YAW      = 3'd2;
    localparam logic [2:0] CFG_DEVID    = 3'd3;
    localparam logic [2:0] CFG_LOCKMASK = 3'd4;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] cam_right;
        logic signed [31:0] cam_down;
        logic signed [31:0] cam_forward;
    } t_in_word;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic [2:0]         lock_flags;
        logic [7:0]         unit_id;
    } t_out_word;

    typedef struct packed {
        logic start;
        logic vect;
    } t_cordic_cmd;

    // atan(2^-i) on a 2^32-per-turn scale
    function automatic logic signed [AW-1:0] atan_q32(input logic [4:0] i);
        case (i)
            5'd0:  atan_q32 = 36'sd536870912;
            5'd1:  atan_q32 = 36'sd316933406;
            5'd2:  atan_q32 = 36'sd167458907;
            5'd3:  atan_q32 = 36'sd85004756;
            5'd4:  atan_q32 = 36'sd42667331;
            5'd5:  atan_q32 = 36'sd21354465;
            5'd6:  atan_q32 = 36'sd10679838;
            5'd7:  atan_q32 = 36'sd5340245;
            5'd8:  atan_q32 = 36'sd2670163;
            5'd9:  atan_q32 = 36'sd1335087;
            5'd10: atan_q32 = 36'sd667544;
            5'd11: atan_q32 = 36'sd333772;
            5'd12: atan_q32 = 36'sd166886;
            5'd13: atan_q32 = 36'sd83443;
            5'd14: atan_q32 = 36'sd41722;
            5'd15: atan_q32 = 36'sd20861;
            5'd16: atan_q32 = 36'sd10430;
            5'd17: atan_q32 = 36'sd5215;
            5'd18: atan_q32 = 36'sd2608;
            5'd19: atan_q32 = 36'sd1304;
            5'd20: atan_q32 = 36'sd652;
            5'd21: atan_q32 = 36'sd326;
            5'd22: atan_q32 = 36'sd163;
            5'd23: atan_q32 = 36'sd81;
            default: atan_q32 = '0;
        endcase
    endfunction

endpackage
`default_nettype wire

// ----- rtl/target_to_gimbal_quaternion.sv -----
`default_nettype none
// Channel  | Dir | Handshake                | Word
// in       | in  | i_in_valid / o_in_stall  | t_in_word  (op, cam_right/down/forward)
// out      | out | o_out_valid / i_out_stall| t_out_word (kind, quat_w..z, lock, id)
// cfg      | in  | i_cfg_we                 | i_cfg_idx, i_cfg_data
//
// Target samples and ms ticks are handled in the idle state. A control tick with a fresh
// target runs 3 serial squares and 4 serial products (each a start, 32 bit steps and a
// done), two vectoring and two rotating CORDIC passes (each a start, CORDIC_STEPS steps
// and a done) and one load of the output word; a target too close gives an identity word.
// Reset is synchronous, active low; config returns to its defaults.
// Input is stalled while a tick is being worked or the output word is stalled.
module target_to_gimbal_quaternion import tgq_pkg::*; #(
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_word    i_in_word,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_word        o_out_word,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    localparam int SH = 32 - ANGLE_BITS;
    localparam logic signed [AW-1:0] RND_HALF = AW'(64'd1 << (SH - 1));
    localparam logic [AW-1:0]        RND_MASK = AW'((64'd1 << SH) - 1);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_SQ   = 8'b0000_0010,
        ST_ATP  = 8'b0000_0100,
        ST_ATY  = 8'b0000_1000,
        ST_ROTP = 8'b0001_0000,
        ST_ROTY = 8'b0010_0000,
        ST_MUL  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } t_state;

    // configuration
    logic [15:0]        r_timeout;
    logic signed [15:0] r_poff, r_yoff;
    logic [7:0]         r_devid;
    logic [2:0]         r_lock;

    // target state
    logic               r_track;
    logic [15:0]        r_age;
    logic signed [31:0] r_sr, r_sd, r_sf;

    // sequencer
    t_state             r_state;
    logic               r_run, r_neg;
    logic [1:0]         r_k;
    logic [65:0]        r_sq;
    logic signed [AW-1:0] r_pa, r_ya;
    logic signed [31:0] r_cp, r_sp, r_cy, r_sy;
    logic signed [15:0] r_qw, r_qx, r_qy, r_qz;

    logic               r_ovalid;
    t_out_word          r_oword;

    logic               in_acc, is_vect, vz, fold_neg, mul_start;
    t_cordic_cmd        c_cmd;
    logic signed [AW-1:0] c_x0, c_y0, c_z0, c_x, c_y, c_z;
    logic               c_done;
    logic signed [AW-1:0] vy, hh, ang, zr, offs;
    logic signed [MW-1:0] m_a, m_b;
    logic signed [2*MW-1:0] m_p;
    logic               m_done;
    logic [65:0]        sq_sum;
    logic signed [65:0] q_t;
    logic signed [20:0] q_v;
    logic signed [15:0] q15;
    logic signed [31:0] c_cos, c_sin;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE) || (r_ovalid && i_out_stall);

    // CORDIC operand setup: pre-fold for vectoring, half angle fold for rotation
    always_comb begin
        is_vect  = (r_state == ST_ATP) || (r_state == ST_ATY);
        vy       = (r_state == ST_ATP) ? AW'(r_sd) : AW'(r_sr);
        vz       = (r_sf == 0) && (vy == 0);
        hh       = ((r_state == ST_ROTP) ? r_pa : r_ya) >>> 1;
        fold_neg = 1'b0;
        if (is_vect) begin
            if (r_sf < 0) begin
                c_x0 = -AW'(r_sf);
                c_y0 = -vy;
                c_z0 = (vy >= 0) ? HALF_TURN : -HALF_TURN;
            end else begin
                c_x0 = AW'(r_sf);
                c_y0 = vy;
                c_z0 = '0;
            end
        end else begin
            c_x0 = GAIN_Q30;
            c_y0 = '0;
            if (hh > QUARTER_TURN) begin
                c_z0 = hh - HALF_TURN; fold_neg = 1'b1;
            end else if (hh < -QUARTER_TURN) begin
                c_z0 = hh + HALF_TURN; fold_neg = 1'b1;
            end else begin
                c_z0 = hh;
            end
        end
        c_cmd.vect  = is_vect;
        c_cmd.start = !r_run && !(is_vect && vz) &&
                      (is_vect || (r_state == ST_ROTP) || (r_state == ST_ROTY));
        // round atan2 to ANGLE_BITS, then add the offset
        offs  = (r_state == ST_ATP) ? (AW'(r_poff) <<< 16) : (AW'(r_yoff) <<< 16);
        zr    = (c_z + RND_HALF) & ~RND_MASK;
        ang   = zr + offs;
        c_cos = r_neg ? 32'(-c_x) : 32'(c_x);
        c_sin = r_neg ? 32'(-c_y) : 32'(c_y);
    end

    // multiplier operands
    always_comb begin
        m_a = r_sr;
        m_b = r_sr;
        if (r_state == ST_SQ) begin
            case (r_k)
                2'd0:    begin m_a = r_sr; m_b = r_sr; end
                2'd1:    begin m_a = r_sd; m_b = r_sd; end
                default: begin m_a = r_sf; m_b = r_sf; end
            endcase
        end else begin
            case (r_k)
                2'd0:    begin m_a = r_cy;  m_b = r_cp; end
                2'd1:    begin m_a = -r_sy; m_b = r_sp; end
                2'd2:    begin m_a = r_cy;  m_b = r_sp; end
                default: begin m_a = r_sy;  m_b = r_cp; end
            endcase
        end
        mul_start = !r_run && ((r_state == ST_SQ) || (r_state == ST_MUL));
        sq_sum    = r_sq + 66'($unsigned(m_p));
        // Q60 -> Q15, round half up, saturate
        q_t = 66'(m_p) + (66'sd1 <<< 44);
        q_v = 21'(q_t >>> 45);
        if (q_v > 21'sd32767)       q15 = 16'sh7fff;
        else if (q_v < -21'sd32768) q15 = 16'sh8000;
        else                        q15 = 16'(q_v);
    end

    tgq_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk, .i_rst_n, .i_cmd(c_cmd), .i_x(c_x0), .i_y(c_y0), .i_z(c_z0),
        .o_x(c_x), .o_y(c_y), .o_z(c_z), .o_done(c_done)
    );

    tgq_mul u_mul (
        .i_clk, .i_rst_n, .i_start(mul_start), .i_a(m_a), .i_b(m_b),
        .o_p(m_p), .o_done(m_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 16'd1000;
            r_poff    <= '0;
            r_yoff    <= '0;
            r_devid   <= '0;
            r_lock    <= 3'd3;
            r_track   <= 1'b0;
            r_age     <= '0;
            r_sr      <= '0;
            r_sd      <= '0;
            r_sf      <= '0;
            r_state   <= ST_IDLE;
            r_run     <= 1'b0;
            r_k       <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TIMEOUT:  r_timeout <= i_cfg_data;
                    CFG_PITCH:    r_poff    <= i_cfg_data;
                    CFG_YAW:      r_yoff    <= i_cfg_data;
                    CFG_DEVID:    r_devid   <= i_cfg_data[7:0];
                    CFG_LOCKMASK: r_lock    <= i_cfg_data[2:0];
                    default: ;
                endcase
            end

            if (r_ovalid && !i_out_stall) r_ovalid <= 1'b0;

            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        case (i_in_word.op)
                            OP_TARGET: begin
                                r_sr    <= i_in_word.cam_right;
                                r_sd    <= i_in_word.cam_down;
                                r_sf    <= i_in_word.cam_forward;
                                r_track <= 1'b1;
                                r_age   <= '0;
                                if (!r_track) begin
                                    r_ovalid <= 1'b1;
                                    r_oword  <= '{kind: KIND_ACQ, quat_w: '0,
                                                  quat_x: '0, quat_y: '0, quat_z: '0,
                                                  lock_flags: '0, unit_id: r_devid};
                                end
                            end
                            OP_MS: begin
                                if (r_age != 16'hffff) r_age <= r_age + 1'b1;
                            end
                            OP_TICK: begin
                                if (r_track) begin
                                    if (r_age > r_timeout) begin
                                        r_track <= 1'b0;
                                    end else begin
                                        r_state <= ST_SQ;
                                        r_k     <= '0;
                                        r_sq    <= '0;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SQ: begin
                    if (mul_start) r_run <= 1'b1;
                    if (m_done) begin
                        r_run <= 1'b0;
                        r_sq  <= sq_sum;
                        if (r_k == 2'd2) begin
                            r_k <= '0;
                            if (sq_sum <= RANGE_SQ_MIN) begin
                                // target too close: identity
                                r_qw    <= 16'sd32767;
                                r_qx    <= '0;
                                r_qy    <= '0;
                                r_qz    <= '0;
                                r_state <= ST_OUT;
                            end else begin
                                r_state <= ST_ATP;
                            end
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                ST_ATP, ST_ATY: begin
                    if (!r_run) begin
                        if (vz) begin
                            // both operands zero: angle is just the offset
                            if (r_state == ST_ATP) begin
                                r_pa <= offs; r_state <= ST_ATY;
                            end else begin
                                r_ya <= offs; r_state <= ST_ROTP;
                            end
                        end else begin
                            r_run <= 1'b1;
                        end
                    end else if (c_done) begin
                        r_run <= 1'b0;
                        if (r_state == ST_ATP) begin
                            r_pa <= ang; r_state <= ST_ATY;
                        end else begin
                            r_ya <= ang; r_state <= ST_ROTP;
                        end
                    end
                end
                ST_ROTP, ST_ROTY: begin
                    if (!r_run) begin
                        r_run <= 1'b1;
                        r_neg <= fold_neg;
                    end else if (c_done) begin
                        r_run <= 1'b0;
                        if (r_state == ST_ROTP) begin
                            r_cp <= c_cos; r_sp <= c_sin; r_state <= ST_ROTY;
                        end else begin
                            r_cy <= c_cos; r_sy <= c_sin; r_state <= ST_MUL;
                            r_k  <= '0;
                        end
                    end
                end
                ST_MUL: begin
                    if (mul_start) r_run <= 1'b1;
                    if (m_done) begin
                        r_run <= 1'b0;
                        r_k   <= r_k + 1'b1;
                        case (r_k)
                            2'd0:    r_qw <= q15;
                            2'd1:    r_qx <= q15;
                            2'd2:    r_qy <= q15;
                            default: begin
                                r_qz    <= q15;
                                r_state <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_OUT: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_ovalid <= 1'b1;
                        r_oword  <= '{kind: KIND_ATT, quat_w: r_qw, quat_x: r_qx,
                                      quat_y: r_qy, quat_z: r_qz,
                                      lock_flags: r_lock, unit_id: r_devid};
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("sequencer state not one-hot");

    a_cordic_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_done |-> (r_state == ST_ATP || r_state == ST_ATY ||
                    r_state == ST_ROTP || r_state == ST_ROTY))
        else $error("CORDIC finished outside an angle step");

    a_mul_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_done |-> (r_state == ST_SQ || r_state == ST_MUL))
        else $error("multiplier finished outside a product step");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && (!r_ovalid || !i_out_stall)) |=> r_ovalid)
        else $error("attitude word not presented");

endmodule
`default_nettype wire

// ----- rtl/tgq_cordic.sv -----
`default_nettype none
module tgq_cordic import tgq_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cordic_cmd           i_cmd,
    input  wire logic signed [AW-1:0]  i_x,
    input  wire logic signed [AW-1:0]  i_y,
    input  wire logic signed [AW-1:0]  i_z,
    output logic signed [AW-1:0]       o_x,
    output logic signed [AW-1:0]       o_y,
    output logic signed [AW-1:0]       o_z,
    output logic                       o_done
);
    localparam int IW = $clog2(CORDIC_STEPS);

    logic signed [AW-1:0] r_x, r_y, r_z;
    logic [IW-1:0]        r_i;
    logic                 r_busy, r_vect, r_done;
    logic signed [AW-1:0] xs, ys, at;
    logic signed [AW-1:0] n_x, n_y, n_z;

    // one micro-rotation per cycle
    always_comb begin
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        at = atan_q32(5'(r_i));
        if (r_vect) begin
            if (!r_y[AW-1]) begin
                n_x = r_x + ys; n_y = r_y - xs; n_z = r_z + at;
            end else begin
                n_x = r_x - ys; n_y = r_y + xs; n_z = r_z - at;
            end
        end else begin
            if (!r_z[AW-1]) begin
                n_x = r_x - ys; n_y = r_y + xs; n_z = r_z - at;
            end else begin
                n_x = r_x + ys; n_y = r_y - xs; n_z = r_z + at;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_x    <= i_x;
                r_y    <= i_y;
                r_z    <= i_z;
                r_vect <= i_cmd.vect;
                r_i    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
                r_i <= r_i + 1'b1;
                if (r_i == IW'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_done = r_done;
endmodule
`default_nettype wire

// ----- rtl/tgq_mul.sv -----
`default_nettype none
module tgq_mul import tgq_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic signed [MW-1:0]   i_a,
    input  wire logic signed [MW-1:0]   i_b,
    output logic signed [2*MW-1:0]      o_p,
    output logic                        o_done
);
    localparam int CW = $clog2(MW);

    logic [MW-1:0]         r_ua, r_hi, r_lo;
    logic                  r_neg, r_busy, r_done;
    logic [CW-1:0]         r_cnt;
    logic signed [2*MW-1:0] r_p;
    logic [MW:0]           sum;
    logic [2*MW-1:0]       prod;

    // shift-and-add, one multiplier bit per cycle
    always_comb begin
        sum  = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_ua} : '0);
        prod = {sum[MW:1], sum[0], r_lo[MW-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_ua   <= i_a[MW-1] ? MW'(-i_a) : MW'(i_a);
                r_lo   <= i_b[MW-1] ? MW'(-i_b) : MW'(i_b);
                r_hi   <= '0;
                r_neg  <= i_a[MW-1] ^ i_b[MW-1];
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_hi  <= prod[2*MW-1:MW];
                r_lo  <= prod[MW-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(MW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_p    <= r_neg ? -$signed(prod) : $signed(prod);
                end
            end
        end
    end

    assign o_p    = r_p;
    assign o_done = r_done;
endmodule
`default_nettype wire
